// ===== design/bcd_hhmm_countdown_timer_macros.svh =====
`ifndef BCD_HHMM_COUNTDOWN_TIMER_MACROS_SVH
`define BCD_HHMM_COUNTDOWN_TIMER_MACROS_SVH

// Check on every clock edge outside reset.
`define BHCT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check on every clock edge, reset included.
`define BHCT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== design/bhct_pkg.sv =====
`default_nettype none

package bhct_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_LOAD  = 2'd3
  } kind_t;

  localparam logic [3:0] DIGIT_MAX    = 4'd9;
  localparam logic [2:0] MIN_TENS_MAX = 3'd5;
  localparam logic [5:0] RELOAD_RESET = 6'd59;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] load_hours_tens;
    logic [3:0] load_hours_units;
    logic [2:0] load_minutes_tens;
    logic [3:0] load_minutes_units;
  } in_item_t;

  typedef struct packed {
    logic       running;
    logic [3:0] hours_tens;
    logic [3:0] hours_units;
    logic [2:0] minutes_tens;
    logic [3:0] minutes_units;
    logic       expired;
    logic       colon_toggle;
  } out_item_t;

  typedef struct packed {
    logic       enabled;
    logic [5:0] second_count;
    logic [3:0] hr_tens;
    logic [3:0] hr_units;
    logic [2:0] min_tens;
    logic [3:0] min_units;
  } timer_state_t;

endpackage

`default_nettype wire

// ===== design/bhct_if.sv =====
`default_nettype none

interface bhct_item_if
  import bhct_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bhct_result_if
  import bhct_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/bhct_step.sv =====
`default_nettype none

module bhct_step
  import bhct_pkg::*;
(
  input  timer_state_t cur,
  input  in_item_t     req,
  input  logic [5:0]   seconds_reload,
  output timer_state_t nxt,
  output out_item_t    res
);

  logic any_nonzero;
  logic last_minute;
  logic expired;
  logic colon;

  assign any_nonzero = (cur.hr_tens != 4'd0) || (cur.hr_units != 4'd0) ||
                       (cur.min_tens != 3'd0) || (cur.min_units != 4'd0);

  // 00:01 and 00:00 both end the countdown
  assign last_minute = (cur.hr_tens == 4'd0) && (cur.hr_units == 4'd0) &&
                       (cur.min_tens == 3'd0) && (cur.min_units[3:1] == 3'd0);

  always_comb begin
    nxt     = cur;
    expired = 1'b0;
    colon   = 1'b0;
    case (req.kind)
      KIND_TICK: begin
        if (cur.enabled) begin
          colon = 1'b1;
          if (cur.second_count != 6'd0) begin
            nxt.second_count = cur.second_count - 6'd1;
          end else begin
            nxt.second_count = seconds_reload;
            // borrow chain over the four digits
            if (last_minute) begin
              nxt.min_units = 4'd0;
              nxt.enabled   = 1'b0;
              expired       = 1'b1;
            end else if (cur.min_units != 4'd0) begin
              nxt.min_units = cur.min_units - 4'd1;
            end else if (cur.min_tens != 3'd0) begin
              nxt.min_tens  = cur.min_tens - 3'd1;
              nxt.min_units = DIGIT_MAX;
            end else if (cur.hr_units != 4'd0) begin
              nxt.hr_units  = cur.hr_units - 4'd1;
              nxt.min_tens  = MIN_TENS_MAX;
              nxt.min_units = DIGIT_MAX;
            end else begin
              nxt.hr_tens   = cur.hr_tens - 4'd1;
              nxt.hr_units  = DIGIT_MAX;
              nxt.min_tens  = MIN_TENS_MAX;
              nxt.min_units = DIGIT_MAX;
            end
          end
        end
      end
      KIND_START: begin
        if (any_nonzero) begin
          nxt.enabled = 1'b1;
        end
      end
      KIND_STOP: begin
        nxt.enabled = 1'b0;
      end
      default: begin
        // load only while stopped
        if (!cur.enabled) begin
          nxt.hr_tens   = req.load_hours_tens;
          nxt.hr_units  = req.load_hours_units;
          nxt.min_tens  = req.load_minutes_tens;
          nxt.min_units = req.load_minutes_units;
        end
      end
    endcase
  end

  assign res.running       = nxt.enabled;
  assign res.hours_tens    = nxt.hr_tens;
  assign res.hours_units   = nxt.hr_units;
  assign res.minutes_tens  = nxt.min_tens;
  assign res.minutes_units = nxt.min_units;
  assign res.expired       = expired;
  assign res.colon_toggle  = colon;

endmodule

`default_nettype wire

// ===== design/bcd_hhmm_countdown_timer.sv =====
// An accepted request waits in s1_item until its step result can enter the result register.
// Throughput: one request per cycle while results are taken; the step logic feeds back
// through the state registers, and the result register lets a new request enter while a
// result waits.
// Reset (rst, synchronous): timer stopped, digits 00:00, prescaler and reload at 59,
// both pipeline stages empty.
`default_nettype none

`include "bcd_hhmm_countdown_timer_macros.svh"

module bcd_hhmm_countdown_timer
  import bhct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [5:0]           cfg_data,
  bhct_item_if.sink            item,
  bhct_result_if.source        result
);

  logic         s1_valid;
  in_item_t     s1_item;
  logic         s1_go;
  logic [5:0]   seconds_reload;
  timer_state_t st;
  timer_state_t st_next;
  out_item_t    res_next;
  logic         res_done;
  logic         res_blink;
  logic         res_time_zero;
  logic         all_idle;

  assign s1_go      = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || s1_go;

  bhct_step u_step (
    .cur            (st),
    .req            (s1_item),
    .seconds_reload (seconds_reload),
    .nxt            (st_next),
    .res            (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  // hold the request register while stage one stalls
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_item <= item.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_reload <= RELOAD_RESET;
    end else if (cfg_we) begin
      seconds_reload <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.enabled      <= 1'b0;
      st.second_count <= RELOAD_RESET;
      st.hr_tens      <= 4'd0;
      st.hr_units     <= 4'd0;
      st.min_tens     <= 3'd0;
      st.min_units    <= 4'd0;
    end else if (s1_go) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_go) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      result.data <= res_next;
    end
  end

  assign res_done      = result.valid && result.data.expired;
  assign res_blink     = result.valid && result.data.colon_toggle && !result.data.expired;
  assign res_time_zero = (result.data.hours_tens == 4'd0) && (result.data.hours_units == 4'd0) &&
                         (result.data.minutes_tens == 3'd0) &&
                         (result.data.minutes_units == 4'd0);
  assign all_idle      = !st.enabled && !s1_valid && !result.valid;

  `BHCT_ASSERT(a_accept_fills_s1, (item.valid && item.ready) |=> s1_valid, "request lost")
  `BHCT_ASSERT(a_expired_stopped, res_done |-> !result.data.running, "expired while running")
  `BHCT_ASSERT(a_expired_zero, res_done |-> res_time_zero, "expired with time left")
  `BHCT_ASSERT(a_colon_running, res_blink |-> result.data.running, "colon blink while stopped")
  `BHCT_ASSERT_ALWAYS(a_reset_stops, $past(rst) |-> all_idle, "state not cleared by reset")

endmodule

`default_nettype wire

// ===== tb/bhct_countdown_checker.sv =====
`timescale 1ns / 1ps

module bhct_countdown_checker
  import bhct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [5:0] cfg_data,
  bhct_item_if       item,
  bhct_result_if     result,
  output int         mismatches,
  output int         readouts_due,
  output int         expiries
);

  // Shadow copy of the timer
  logic       run_q;
  logic [5:0] prescale_q;
  logic [5:0] reload_q;
  logic [3:0] hr_tens_q;
  logic [3:0] hr_units_q;
  logic [2:0] min_tens_q;
  logic [3:0] min_units_q;

  out_item_t  readouts_q[$];
  int         fail_count = 0;
  int         expiry_count = 0;

  assign mismatches = fail_count;
  assign expiries   = expiry_count;

  // Drop one minute with BCD borrows; returns one when the countdown ran out.
  function automatic logic take_minute();
    logic ran_out;
    ran_out = 1'b0;
    if (hr_tens_q == 0 && hr_units_q == 0 && min_tens_q == 0 && min_units_q == 1)
      min_units_q = '0;
    if (min_units_q != 0) begin
      min_units_q = min_units_q - 4'd1;
    end else if (min_tens_q != 0) begin
      min_tens_q  = min_tens_q - 3'd1;
      min_units_q = DIGIT_MAX;
    end else if (hr_units_q != 0) begin
      hr_units_q  = hr_units_q - 4'd1;
      min_tens_q  = MIN_TENS_MAX;
      min_units_q = DIGIT_MAX;
    end else if (hr_tens_q != 0) begin
      hr_tens_q   = hr_tens_q - 4'd1;
      hr_units_q  = DIGIT_MAX;
      min_tens_q  = MIN_TENS_MAX;
      min_units_q = DIGIT_MAX;
    end else begin
      run_q   = 1'b0;
      ran_out = 1'b1;
    end
    return ran_out;
  endfunction

  function automatic out_item_t next_readout(input in_item_t req);
    out_item_t r;
    r = '0;
    case (req.kind)
      KIND_TICK: begin
        if (run_q) begin
          r.colon_toggle = 1'b1;
          if (prescale_q != 0) begin
            prescale_q = prescale_q - 6'd1;
          end else begin
            prescale_q = reload_q;
            r.expired  = take_minute();
          end
        end
      end
      KIND_START: begin
        if (hr_tens_q != 0 || hr_units_q != 0 || min_tens_q != 0 || min_units_q != 0)
          run_q = 1'b1;
      end
      KIND_STOP: begin
        run_q = 1'b0;
      end
      default: begin
        // load is ignored while running
        if (!run_q) begin
          hr_tens_q   = req.load_hours_tens;
          hr_units_q  = req.load_hours_units;
          min_tens_q  = req.load_minutes_tens;
          min_units_q = req.load_minutes_units;
        end
      end
    endcase
    r.running       = run_q;
    r.hours_tens    = hr_tens_q;
    r.hours_units   = hr_units_q;
    r.minutes_tens  = min_tens_q;
    r.minutes_units = min_units_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [3:0] want_v,
                             input logic [3:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t got;
    if (rst) begin
      run_q       = 1'b0;
      prescale_q  = RELOAD_RESET;
      reload_q    = RELOAD_RESET;
      hr_tens_q   = '0;
      hr_units_q  = '0;
      min_tens_q  = '0;
      min_units_q = '0;
      readouts_q.delete();
      readouts_due <= 0;
    end else begin
      if (cfg_we)
        reload_q = cfg_data;
      if (result.valid && result.ready) begin
        got = result.data;
        if (readouts_q.size() == 0) begin
          $display("%0t: readout with nothing expected, expected none, got %p", $time, got);
          fail_count++;
        end else begin
          want = readouts_q.pop_front();
          check_field("running", want.running, got.running);
          check_field("hours_tens", want.hours_tens, got.hours_tens);
          check_field("hours_units", want.hours_units, got.hours_units);
          check_field("minutes_tens", want.minutes_tens, got.minutes_tens);
          check_field("minutes_units", want.minutes_units, got.minutes_units);
          check_field("expired", want.expired, got.expired);
          check_field("colon_toggle", want.colon_toggle, got.colon_toggle);
        end
      end
      if (item.valid && item.ready) begin
        want = next_readout(item.data);
        if (want.expired)
          expiry_count++;
        readouts_q.push_back(want);
      end
      readouts_due <= readouts_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bhct_pkg::*;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [5:0] cfg_data;

  int         mismatches;
  int         readouts_due;
  int         expiries;

  int         tx_idle_pct = 31;
  int         rx_idle_pct = 31;
  bit         hold_results = 1'b0;
  int         requests_sent = 0;
  int         reloads_written = 0;

  bhct_item_if   req_ch ();
  bhct_result_if rsp_ch ();

  bcd_hhmm_countdown_timer u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (req_ch),
    .result   (rsp_ch)
  );

  bhct_countdown_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .item         (req_ch),
    .result       (rsp_ch),
    .mismatches   (mismatches),
    .readouts_due (readouts_due),
    .expiries     (expiries)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d readouts outstanding", readouts_due);
    $display("Some tests failed");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold on request
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        rsp_ch.ready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  function automatic in_item_t make_req(input kind_t k, input int ht, input int hu,
                                        input int mt, input int mu);
    in_item_t req;
    req.kind               = k;
    req.load_hours_tens    = 4'(ht);
    req.load_hours_units   = 4'(hu);
    req.load_minutes_tens  = 3'(mt);
    req.load_minutes_units = 4'(mu);
    return req;
  endfunction

  task automatic send_request(input in_item_t req);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= req;
    do @(posedge clk); while (!req_ch.ready);
    requests_sent++;
  endtask

  // Non-load kinds carry random digits, which must be ignored
  task automatic send_op(input kind_t k);
    send_request(make_req(k, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 7), $urandom_range(0, 15)));
  endtask

  task automatic send_load(input int ht, input int hu, input int mt, input int mu);
    send_request(make_req(KIND_LOAD, ht, hu, mt, mu));
  endtask

  // Hold the request side until every readout is back
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (readouts_due != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reload(input logic [5:0] value);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    reloads_written++;
  endtask

  // Load a time, start it and tick it down for a while
  task automatic countdown_run(input int reload);
    int style;
    int ticks;
    style = $urandom_range(0, 9);
    if ($urandom_range(0, 99) < 80)
      send_op(KIND_STOP);
    if (style < 5)
      send_load(0, 0, 0, $urandom_range(1, 2));
    else if (style < 8)
      send_load($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 1));
    else if (style == 8)
      send_load($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 7),
                $urandom_range(0, 15));
    else if ($urandom_range(0, 1) == 1)
      send_load(9, 9, 5, 9);
    else
      send_load(15, 15, 7, 15);
    send_op(KIND_START);
    ticks = $urandom_range(1, (reload + 1) * 3 + 2);
    repeat (ticks) begin
      if ($urandom_range(0, 99) < 4)
        send_op(kind_t'($urandom_range(1, 3)));
      else
        send_op(KIND_TICK);
    end
  endtask

  task automatic run_phase(input int count, input int reload);
    int first;
    first = requests_sent;
    while (requests_sent - first < count) begin
      if ($urandom_range(0, 99) < 70)
        countdown_run(reload);
      else
        send_request(make_req(kind_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                              $urandom_range(0, 15), $urandom_range(0, 7),
                              $urandom_range(0, 15)));
    end
  endtask

  initial begin
    int waited;
    int mid_reload;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: stopped ticks, zero start, out-of-range digits, ignored load
    send_op(KIND_TICK);
    send_op(KIND_START);
    send_op(KIND_STOP);
    send_load(15, 15, 7, 15);
    send_op(KIND_START);
    send_load(1, 2, 3, 4);
    send_op(KIND_START);
    send_op(KIND_TICK);
    send_op(KIND_TICK);
    send_op(KIND_TICK);
    send_op(KIND_STOP);
    send_op(KIND_TICK);
    send_load(0, 0, 0, 1);
    send_op(KIND_START);
    send_op(KIND_TICK);
    send_op(KIND_STOP);
    send_load(9, 9, 5, 9);
    send_load(0, 0, 0, 0);
    send_op(KIND_START);
    send_op(KIND_TICK);
    send_load(0, 1, 0, 0);

    write_reload(6'd0);
    run_phase(190, 0);

    write_reload(6'd63);
    run_phase(60, 63);
    hold_results = 1'b1;
    run_phase(130, 63);

    // No idling on either side
    write_reload(6'd1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(190, 1);
    tx_idle_pct = 31;
    rx_idle_pct = 31;

    mid_reload = $urandom_range(2, 62);
    write_reload(6'(mid_reload));
    run_phase(90, mid_reload);
    settle();
    run_phase(100, mid_reload);

    write_reload(6'd59);
    run_phase(150, 59);

    req_ch.valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (readouts_due != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);

    if (readouts_due != 0)
      $display("%0d readouts never arrived", readouts_due);
    $display("Ran %0d requests over %0d prescaler reload settings (0, 1, 63 among them);",
             requests_sent, reloads_written);
    $display("%0d countdowns ran out, %0d mismatches seen.", expiries, mismatches);
    if (mismatches == 0 && readouts_due == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
